FILE: rtl/fbwc_pkg.sv
// Shared constants, codes and types of the flash block write coalescer.
package fbwc_pkg;

  localparam int KIND_W          = 2;
  localparam int ADDR_W          = 16;
  localparam int OFFS_W          = 7;
  localparam int DATA_W          = 8;
  localparam int OKIND_W         = 2;
  localparam int VALUE_W         = 16;
  localparam int WADDR_W         = ADDR_W - 1;
  localparam int BLOCK_BYTES_DEF = 32;
  // Slot field wide enough for the largest supported block of 32 bytes
  localparam int SLOT_MAX_W      = 5;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [ADDR_W-1:0]  NO_BLOCK    = 16'hFFFF;
  localparam logic [VALUE_W-1:0] NO_TARGET   = 16'hFFFF;
  localparam logic [DATA_W-1:0]  ERASED_BYTE = 8'hFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_END    = 2'd1,
    KIND_RESET  = 2'd2,
    KIND_UNUSED = 2'd3
  } in_kind_e;

  typedef enum logic [OKIND_W-1:0] {
    OUT_ADDR  = 2'd0,
    OUT_DATA  = 2'd1,
    OUT_ERASE = 2'd2,
    OUT_PROG  = 2'd3
  } out_kind_e;

  typedef enum logic [1:0] {
    OP_WRITE       = 2'd0,
    OP_FLUSH_WRITE = 2'd1,
    OP_FLUSH       = 2'd2,
    OP_NO_TARGET   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [WADDR_W-1:0]    word_addr;
    logic [SLOT_MAX_W-1:0] slot;
    logic [DATA_W-1:0]     data;
  } cmd_t;

endpackage

FILE: rtl/fbwc_if.sv
// Valid/ready channel interfaces for write items and result beats.
interface fbwc_in_if import fbwc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ADDR_W-1:0]   call_addr;
  logic [OFFS_W-1:0]   byte_offset;
  logic [DATA_W-1:0]   data_byte;

  modport source (output valid, kind, call_addr, byte_offset, data_byte, input ready);
  modport sink   (input valid, kind, call_addr, byte_offset, data_byte, output ready);
endinterface

interface fbwc_out_if import fbwc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OKIND_W-1:0]  out_kind;
  logic [VALUE_W-1:0]  out_value;
  logic                last;

  modport source (output valid, out_kind, out_value, last, input ready);
  modport sink   (input valid, out_kind, out_value, last, output ready);
endinterface

FILE: rtl/fbwc_front.sv
// Front end: takes write items, works out block base and slot, decides flushes.
module fbwc_front import fbwc_pkg::*; #(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fbwc_in_if.sink       in_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output cmd_t          push_cmd_o
);

  // Exact division by the block size: q = (x * RecipMul) >> Sh for any x below 2^XW
  localparam int XW = ADDR_W + 1;
  localparam int Sh = XW + $clog2(BLOCK_BYTES);
  localparam int MW = XW + 1;
  localparam int PW = XW + MW;
  localparam logic [MW-1:0] RecipMul =
      MW'(((64'd1 << Sh) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));
  localparam logic [XW-1:0] BlockX = XW'(BLOCK_BYTES);

  logic              s1_v_q;
  in_kind_e          s1_kind_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [OFFS_W-1:0] s1_offs_q;
  logic [DATA_W-1:0] s1_data_q;

  logic              s2_v_q;
  in_kind_e          s2_kind_q;
  logic              s2_first_q;
  logic [DATA_W-1:0] s2_data_q;
  logic [XW-1:0]     s2_qbase_q;
  logic [XW-1:0]     s2_qslot_q;
  logic [XW-1:0]     s2_sum_q;

  logic [ADDR_W-1:0] held_addr_q, held_addr_d;
  logic              held_v_q, held_v_d;
  logic              empty_q, empty_d;

  logic [XW-1:0]     s1_sum;
  logic [PW-1:0]     prod_base, prod_slot;
  logic [ADDR_W-1:0] base;
  logic [XW-1:0]     slot_full;
  logic              push_v;
  cmd_t              cmd;
  logic              s2_fire, s2_free, s1_free, in_fire;

  assign s1_sum    = XW'(s1_addr_q) + XW'(s1_offs_q);
  assign prod_base = PW'(s1_addr_q) * PW'(RecipMul);
  assign prod_slot = PW'(s1_sum) * PW'(RecipMul);

  assign base      = ADDR_W'(s2_qbase_q * BlockX);
  assign slot_full = s2_sum_q - XW'(s2_qslot_q * BlockX);

  always_comb begin
    push_v         = 1'b0;
    cmd.op         = OP_WRITE;
    cmd.word_addr  = held_addr_q[ADDR_W-1:1];
    cmd.slot       = SLOT_MAX_W'(slot_full);
    cmd.data       = s2_data_q;
    held_addr_d    = held_addr_q;
    held_v_d       = held_v_q;
    empty_d        = empty_q;
    case (s2_kind_q)
      KIND_WRITE: begin
        push_v = 1'b1;
        // A call start in another block pushes out the held one first
        if (s2_first_q && held_v_q && (base != held_addr_q)) begin
          cmd.op = OP_FLUSH_WRITE;
        end
        held_addr_d = base;
        held_v_d    = 1'b1;
        empty_d     = 1'b0;
      end
      KIND_END: begin
        if (!empty_q) begin
          push_v      = 1'b1;
          cmd.op      = OP_FLUSH;
          held_addr_d = NO_BLOCK;
          held_v_d    = 1'b0;
          empty_d     = 1'b1;
        end
      end
      KIND_RESET: begin
        push_v = 1'b1;
        cmd.op = OP_NO_TARGET;
      end
      default: ;
    endcase
  end

  assign s2_fire      = s2_v_q && (!push_v || push_ready_i);
  assign s2_free      = !s2_v_q || s2_fire;
  assign s1_free      = !s1_v_q || s2_free;
  assign in_fire      = in_i.valid && s1_free;
  assign in_i.ready   = s1_free;
  assign push_valid_o = s2_v_q && push_v;
  assign push_cmd_o   = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      held_addr_q <= NO_BLOCK;
      held_v_q    <= 1'b0;
      empty_q     <= 1'b1;
    end else begin
      if (s1_free) begin
        s1_v_q <= in_i.valid;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
      if (s2_fire) begin
        held_addr_q <= held_addr_d;
        held_v_q    <= held_v_d;
        empty_q     <= empty_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= in_kind_e'(in_i.kind);
      s1_addr_q <= in_i.call_addr;
      s1_offs_q <= in_i.byte_offset;
      s1_data_q <= in_i.data_byte;
    end
    if (s1_v_q && s2_free) begin
      s2_kind_q  <= s1_kind_q;
      s2_first_q <= (s1_offs_q == '0);
      s2_data_q  <= s1_data_q;
      s2_qbase_q <= XW'(prod_base >> Sh);
      s2_qslot_q <= XW'(prod_slot >> Sh);
      s2_sum_q   <= s1_sum;
    end
  end

endmodule

FILE: rtl/fbwc_fifo.sv
// Short command queue between the front end and the flush engine.
module fbwc_fifo import fbwc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  cmd_t            slots_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = slots_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: rtl/fbwc_back.sv
// Back end: block buffer, byte stores and the flush sequence onto the result port.
module fbwc_back import fbwc_pkg::*; #(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  fbwc_out_if.source out_o
);

  localparam int SlotW = $clog2(BLOCK_BYTES);
  localparam logic [SlotW-1:0] LastIdx = SlotW'(BLOCK_BYTES - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DATA  = 4'b0010,
    ST_ERASE = 4'b0100,
    ST_PROG  = 4'b1000
  } back_state_e;

  back_state_e       state_q, state_d;
  cmd_t              cmd_q;
  logic [SlotW-1:0]  idx_q, idx_d;
  logic [DATA_W-1:0] mem [BLOCK_BYTES];
  logic [BLOCK_BYTES-1:0] written_q, written_d;
  logic [DATA_W-1:0] rd_q;
  logic              rdv_q;

  logic              out_valid_q;
  out_kind_e         out_kind_q;
  logic [VALUE_W-1:0] out_value_q;
  logic              out_last_q;

  logic              out_free, load_out, latch_cmd, clear_all;
  logic              we, re;
  logic [SlotW-1:0]  waddr, raddr;
  logic [DATA_W-1:0] wdata, rd_byte;
  out_kind_e         okind;
  logic [VALUE_W-1:0] ovalue;
  logic              olast;

  assign out_free = !out_valid_q || out_o.ready;
  // Slots not stored since the last flush read as erased flash
  assign rd_byte  = rdv_q ? rd_q : ERASED_BYTE;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cmd_pop_o = 1'b0;
    latch_cmd = 1'b0;
    clear_all = 1'b0;
    load_out  = 1'b0;
    okind     = OUT_ADDR;
    ovalue    = '0;
    olast     = 1'b0;
    we        = 1'b0;
    waddr     = cmd_i.slot[SlotW-1:0];
    wdata     = cmd_i.data;
    re        = 1'b0;
    raddr     = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_WRITE: begin
              cmd_pop_o = 1'b1;
              we        = 1'b1;
            end
            OP_NO_TARGET: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                load_out  = 1'b1;
                ovalue    = NO_TARGET;
                olast     = 1'b1;
              end
            end
            default: begin
              // Start a flush: send the word address, fetch the first byte
              if (out_free) begin
                cmd_pop_o = 1'b1;
                latch_cmd = 1'b1;
                load_out  = 1'b1;
                ovalue    = VALUE_W'(cmd_i.word_addr);
                re        = 1'b1;
                idx_d     = '0;
                state_d   = ST_DATA;
              end
            end
          endcase
        end
      end
      ST_DATA: begin
        if (out_free) begin
          load_out = 1'b1;
          okind    = OUT_DATA;
          ovalue   = VALUE_W'(rd_byte);
          if (idx_q == LastIdx) begin
            state_d = ST_ERASE;
          end else begin
            re    = 1'b1;
            raddr = idx_q + 1'b1;
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_ERASE: begin
        if (out_free) begin
          load_out = 1'b1;
          okind    = OUT_ERASE;
          state_d  = ST_PROG;
        end
      end
      ST_PROG: begin
        if (out_free) begin
          load_out  = 1'b1;
          okind     = OUT_PROG;
          olast     = 1'b1;
          clear_all = 1'b1;
          waddr     = cmd_q.slot[SlotW-1:0];
          wdata     = cmd_q.data;
          // The byte that caused the flush lands in the freshly erased buffer
          we        = (cmd_q.op == OP_FLUSH_WRITE);
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    written_d = clear_all ? '0 : written_q;
    if (we) begin
      written_d[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      written_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      written_q <= written_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q  <= mem[raddr];
      rdv_q <= written_q[raddr];
    end
    if (latch_cmd) begin
      cmd_q <= cmd_i;
    end
    if (load_out) begin
      out_kind_q  <= okind;
      out_value_q <= ovalue;
      out_last_q  <= olast;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_kind  = out_kind_q;
  assign out_o.out_value = out_value_q;
  assign out_o.last      = out_last_q;

endmodule

FILE: rtl/flash_block_write_coalescer_unit.sv
// Top level of the flash block write coalescer.
// Byte writes are gathered into a BLOCK_BYTES block buffer that reads as 0xFF
// while empty. A write item passes a two-stage front end (block base and slot
// by reciprocal multiplication, then flush decision) into a two-entry command
// queue, so with the back end free one item is taken every cycle, each held in
// both stages before the push. A flush (a call start in a new block,
// or an end item with data held) occupies the back end for BLOCK_BYTES + 3
// result beats, one per cycle while the sink is ready: word address, every
// buffer byte, erase trigger and program trigger, the last one flagged. The
// front end keeps taking items until the queue fills. A reset-target item
// gives the single beat 0xFFFF. Per-slot valid bits clear the whole buffer
// when the program trigger is sent, so there is no clearing pass after reset.
module flash_block_write_coalescer_unit import fbwc_pkg::*; #(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fbwc_in_if.sink    in_i,
  fbwc_out_if.source out_o
);

  logic push_valid, push_ready, pop_valid, pop;
  cmd_t push_cmd, pop_cmd;

  fbwc_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  fbwc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_cmd_o    (pop_cmd)
  );

  fbwc_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (pop),
    .out_o       (out_o)
  );

endmodule

FILE: rtl/fbwc_checker.sv
// Port-level checks on the result channel of the coalescer, bound to the top level.
module fbwc_checker import fbwc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [OKIND_W-1:0] out_kind_i,
  input logic [VALUE_W-1:0] out_value_i,
  input logic               out_last_i
);

  logic out_beat;
  assign out_beat = out_valid_i && out_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i)
      && $stable(out_value_i) && $stable(out_last_i))
    else $error("result beat changed while stalled");

  a_erase_then_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && (out_kind_i == OUT_ERASE) |=> out_valid_i && (out_kind_i == OUT_PROG))
    else $error("erase trigger not followed by program trigger");

  a_addr_then_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && (out_kind_i == OUT_ADDR) && !out_last_i
      |=> out_valid_i && (out_kind_i == OUT_DATA))
    else $error("flush address not followed by buffer data");

  a_prog_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == OUT_PROG) |-> out_last_i && (out_value_i == '0))
    else $error("program trigger must close the item with a zero value");

endmodule

bind flash_block_write_coalescer_unit fbwc_checker u_fbwc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.out_kind),
  .out_value_i (out_o.out_value),
  .out_last_i  (out_o.last)
);
